// ===== rtl/core/sfs_pkg.sv =====
// sfs_pkg: shared types and constants of the subtitle frame shifter
// no dependencies; used by every module in rtl/core
package sfs_pkg;

  // field and register widths
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned RATE_W     = 8;
  localparam int unsigned DELAY_W    = 23;
  localparam int unsigned SUM_W      = 32;
  localparam int unsigned PROD_W     = 31;
  localparam int unsigned REM_W      = 10;
  localparam int unsigned BCD_DIGITS = 10;
  localparam int unsigned DIG_CNT_W  = 4;
  localparam int unsigned CFG_IDX_W  = 1;

  localparam int unsigned MAX_DIGITS_DEF = 9;
  localparam int unsigned MS_PER_S       = 1000;

  localparam logic [RATE_W-1:0]  FRAME_RATE_RST = 8'd25;
  localparam logic [DELAY_W-1:0] DELAY_MS_RST   = '0;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_RATE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_DELAY_MS   = 1'b1;

  // characters
  localparam logic [BYTE_W-1:0] CH_LF     = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_CR     = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_MINUS  = 8'h2D;
  localparam logic [BYTE_W-1:0] CH_ZERO   = 8'h30;
  localparam logic [BYTE_W-1:0] CH_NINE   = 8'h39;
  localparam logic [BYTE_W-1:0] CH_LBRACE = 8'h7B;
  localparam logic [BYTE_W-1:0] CH_RBRACE = 8'h7D;

  typedef enum logic [4:0] {
    ST_OPEN1,
    ST_NUM1,
    ST_OPEN2,
    ST_NUM2,
    ST_FIRST,
    ST_TEXT,
    ST_OFF,
    ST_SUM,
    ST_CONV,
    ST_OB,
    ST_MINUS,
    ST_SKIP,
    ST_DIG,
    ST_CB,
    ST_TXT,
    ST_NL,
    ST_STOP
  } sfs_state_e;

  typedef enum logic [2:0] {
    OFF_IDLE,
    OFF_MUL,
    OFF_ADJ,
    OFF_DIV,
    OFF_DONE
  } off_state_e;

  typedef struct packed {
    logic start;
    logic shift;
  } bcd_ctrl_t;

endpackage

// ===== rtl/core/sfs_offset.sv =====
// sfs_offset: frame offset floor(frame_rate * delay_ms / 1000)
// bit-serial shift-add multiply, then restoring division one bit a cycle
// depends on sfs_pkg
module sfs_offset (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start_i,
  input  logic        [sfs_pkg::RATE_W-1:0]     rate_i,
  input  logic        [sfs_pkg::DELAY_W-1:0]    delay_i,
  output logic                                  done_o,
  output logic signed [sfs_pkg::SUM_W-1:0]      off_o
);

  localparam int unsigned PW   = sfs_pkg::PROD_W;
  localparam int unsigned CntW = $clog2(PW);
  localparam int unsigned RW   = sfs_pkg::REM_W;

  sfs_pkg::off_state_e state_q, state_d;

  logic [PW-1:0]                mcand_q, mcand_d;
  logic [sfs_pkg::RATE_W-1:0]   mplier_q, mplier_d;
  logic [PW-1:0]                acc_q, acc_d;
  logic [RW-1:0]                rem_q, rem_d;
  logic                         neg_q, neg_d;
  logic [CntW-1:0]              cnt_q, cnt_d;

  logic [sfs_pkg::DELAY_W-1:0]  delay_mag;
  logic [RW:0]                  trial;
  logic                         trial_ge;
  logic [sfs_pkg::SUM_W-1:0]    quot_ext;

  assign delay_mag = delay_i[sfs_pkg::DELAY_W-1] ? (~delay_i + 1'b1) : delay_i;
  assign trial     = {rem_q, acc_q[PW-1]};
  assign trial_ge  = trial >= (RW+1)'(sfs_pkg::MS_PER_S);
  assign quot_ext  = sfs_pkg::SUM_W'(acc_q);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sfs_pkg::OFF_IDLE: if (start_i) state_d = sfs_pkg::OFF_MUL;
      sfs_pkg::OFF_MUL:  if (cnt_q == CntW'(sfs_pkg::RATE_W - 1)) state_d = sfs_pkg::OFF_ADJ;
      sfs_pkg::OFF_ADJ:  state_d = sfs_pkg::OFF_DIV;
      sfs_pkg::OFF_DIV:  if (cnt_q == CntW'(PW - 1)) state_d = sfs_pkg::OFF_DONE;
      sfs_pkg::OFF_DONE: state_d = sfs_pkg::OFF_IDLE;
      default:           state_d = sfs_pkg::OFF_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    mcand_d  = mcand_q;
    mplier_d = mplier_q;
    acc_d    = acc_q;
    rem_d    = rem_q;
    neg_d    = neg_q;
    cnt_d    = cnt_q;
    done_o   = 1'b0;
    unique case (state_q)
      sfs_pkg::OFF_IDLE: begin
        if (start_i) begin
          mcand_d  = PW'(delay_mag);
          mplier_d = rate_i;
          acc_d    = '0;
          neg_d    = delay_i[sfs_pkg::DELAY_W-1];
          cnt_d    = '0;
        end
      end
      sfs_pkg::OFF_MUL: begin
        if (mplier_q[0]) acc_d = acc_q + mcand_q;
        mcand_d  = {mcand_q[PW-2:0], 1'b0};
        mplier_d = {1'b0, mplier_q[sfs_pkg::RATE_W-1:1]};
        cnt_d    = cnt_q + 1'b1;
      end
      sfs_pkg::OFF_ADJ: begin
        // floor of a negative quotient: divide the magnitude rounded up
        if (neg_q) acc_d = acc_q + PW'(sfs_pkg::MS_PER_S - 1);
        rem_d = '0;
        cnt_d = '0;
      end
      sfs_pkg::OFF_DIV: begin
        rem_d = trial_ge ? RW'(trial - (RW+1)'(sfs_pkg::MS_PER_S)) : trial[RW-1:0];
        acc_d = {acc_q[PW-2:0], trial_ge};
        cnt_d = cnt_q + 1'b1;
      end
      sfs_pkg::OFF_DONE: done_o = 1'b1;
      default: ;
    endcase
  end

  assign off_o = neg_q ? $signed(~quot_ext + 1'b1) : $signed(quot_ext);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sfs_pkg::OFF_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mcand_q  <= mcand_d;
    mplier_q <= mplier_d;
    acc_q    <= acc_d;
    rem_q    <= rem_d;
    neg_q    <= neg_d;
  end

endmodule

// ===== rtl/core/sfs_bcd.sv =====
// sfs_bcd: bit-serial binary to decimal converter (shift and add three)
// digits leave most significant first through a nibble shift register
// depends on sfs_pkg
module sfs_bcd (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  sfs_pkg::bcd_ctrl_t              ctrl_i,
  input  logic [sfs_pkg::SUM_W-1:0]       bin_i,
  output logic                            done_o,
  output logic [3:0]                      digit_o
);

  localparam int unsigned BW   = sfs_pkg::SUM_W;
  localparam int unsigned DW   = 4 * sfs_pkg::BCD_DIGITS;
  localparam int unsigned CntW = $clog2(BW);

  logic [BW-1:0]   bin_q, bin_d;
  logic [DW-1:0]   bcd_q, bcd_d;
  logic [DW-1:0]   bcd_adj;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic            done_q, done_d;

  // add three to every digit of five or more before the shift
  always_comb begin
    for (int i = 0; i < int'(sfs_pkg::BCD_DIGITS); i++) begin
      bcd_adj[4*i +: 4] = (bcd_q[4*i +: 4] >= 4'd5) ? bcd_q[4*i +: 4] + 4'd3
                                                  : bcd_q[4*i +: 4];
    end
  end

  always_comb begin
    bin_d  = bin_q;
    bcd_d  = bcd_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (ctrl_i.start) begin
      bin_d  = bin_i;
      bcd_d  = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      bcd_d = {bcd_adj[DW-2:0], bin_q[BW-1]};
      bin_d = {bin_q[BW-2:0], 1'b0};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntW'(BW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end else if (ctrl_i.shift) begin
      bcd_d = {bcd_q[DW-5:0], 4'b0000};
    end
  end

  assign done_o  = done_q;
  assign digit_o = bcd_q[DW-1 -: 4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
    bcd_q <= bcd_d;
  end

endmodule

// ===== rtl/core/subtitle_frame_shifter_core.sv =====
// subtitle_frame_shifter_core: top level of the subtitle frame shifter
// instantiates sfs_offset and sfs_bcd; depends on sfs_pkg
//
// Rewrites lines of the form {start}{end}text, one byte per input transaction,
// adding floor(rate * delay / 1000) to both frame numbers, with the rate in frames per
// second and the delay in milliseconds. Text bytes after the first pass through at one
// per cycle while the output accepts them. The first text byte of a line starts the
// header burst: the offset unit runs 8 multiply steps, a rounding step, 31 divide steps
// and a done state, then each frame number passes through the bit-serial decimal
// converter, drops its leading zeros and sends its characters at one per cycle while
// the output accepts them. Header and number bytes are taken without producing output.
// A format error, a carriage return or a number with more than MAX_DIGITS digits gives
// one result with tuser set and tdata zero; after it all input is accepted and dropped
// until reset. Configuration must be written only while no line is in flight; the block
// itself does not enforce this.
module subtitle_frame_shifter_core #(
  parameter int unsigned MAX_DIGITS = sfs_pkg::MAX_DIGITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [sfs_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [sfs_pkg::DELAY_W-1:0]        cfg_data_i,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [sfs_pkg::BYTE_W-1:0]         s_axis_tdata,  // [7:0] in_byte
  input  logic                               s_axis_tlast,  // end_of_input
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [sfs_pkg::BYTE_W-1:0]         m_axis_tdata,  // [7:0] out_byte
  output logic                               m_axis_tuser,  // [0] error
  output logic                               m_axis_tlast   // last
);

  localparam int unsigned FrameW = $clog2(10 ** MAX_DIGITS);
  localparam int unsigned CntW   = $clog2(MAX_DIGITS + 1);
  localparam int unsigned SW     = sfs_pkg::SUM_W;

  sfs_pkg::sfs_state_e state_q, state_d;

  logic [sfs_pkg::RATE_W-1:0]  rate_q;
  logic [sfs_pkg::DELAY_W-1:0] delay_q;

  logic [FrameW-1:0]             start_q, start_d;
  logic [FrameW-1:0]             end_q, end_d;
  logic [CntW-1:0]               cnt_q, cnt_d;
  logic [sfs_pkg::BYTE_W-1:0]    txt_q, txt_d;
  logic                          eoi_q, eoi_d;
  logic                          sel_q, sel_d;
  logic                          neg_q, neg_d;
  logic signed [SW-1:0]          off_q, off_d;
  logic [sfs_pkg::DIG_CNT_W-1:0] left_q, left_d;

  logic                       out_vld_q;
  logic [sfs_pkg::BYTE_W-1:0] out_byte_q;
  logic                       out_err_q, out_last_q;
  logic                       out_load;
  logic [sfs_pkg::BYTE_W-1:0] out_byte_n;
  logic                       out_err_n, out_last_n;
  logic                       out_free;

  logic                       in_acc, parse_st, fail;
  logic                       is_digit, is_lbr, is_rbr, is_lf, is_cr;
  logic [3:0]                 dig_val;
  logic [FrameW-1:0]          frame_cur;
  logic [FrameW+2:0]          frame_x10;
  logic [FrameW-1:0]          num_sel;
  logic signed [SW-1:0]       sum_v;
  logic [SW-1:0]              sum_mag;

  logic                       off_start, off_done;
  logic signed [SW-1:0]       off_val;
  sfs_pkg::bcd_ctrl_t         bcd_ctl;
  logic [SW-1:0]              bcd_bin;
  logic                       bcd_done;
  logic [3:0]                 bcd_digit;
  logic                       skip_zero;

  sfs_offset u_offset (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (off_start),
    .rate_i  (rate_q),
    .delay_i (delay_q),
    .done_o  (off_done),
    .off_o   (off_val)
  );

  sfs_bcd u_bcd (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (bcd_ctl),
    .bin_i   (bcd_bin),
    .done_o  (bcd_done),
    .digit_o (bcd_digit)
  );

  assign is_digit = (s_axis_tdata >= sfs_pkg::CH_ZERO) && (s_axis_tdata <= sfs_pkg::CH_NINE);
  assign is_lbr   = s_axis_tdata == sfs_pkg::CH_LBRACE;
  assign is_rbr   = s_axis_tdata == sfs_pkg::CH_RBRACE;
  assign is_lf    = s_axis_tdata == sfs_pkg::CH_LF;
  assign is_cr    = s_axis_tdata == sfs_pkg::CH_CR;
  assign dig_val  = s_axis_tdata[3:0];

  assign out_free = !out_vld_q || m_axis_tready;
  assign parse_st = (state_q == sfs_pkg::ST_OPEN1) || (state_q == sfs_pkg::ST_NUM1)
                 || (state_q == sfs_pkg::ST_OPEN2) || (state_q == sfs_pkg::ST_NUM2)
                 || (state_q == sfs_pkg::ST_FIRST) || (state_q == sfs_pkg::ST_TEXT);
  assign s_axis_tready = (parse_st && out_free) || (state_q == sfs_pkg::ST_STOP);
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  // decimal accumulation of the frame number being parsed
  assign frame_cur = (state_q == sfs_pkg::ST_NUM2) ? end_q : start_q;
  assign frame_x10 = {frame_cur, 3'b000} + {2'b00, frame_cur, 1'b0} + (FrameW+3)'(dig_val);

  assign num_sel = sel_q ? end_q : start_q;
  assign sum_v   = $signed(SW'(num_sel)) + off_q;
  assign sum_mag = sum_v[SW-1] ? (~sum_v + 1'b1) : sum_v;

  assign skip_zero = (bcd_digit == 4'd0) && (left_q > sfs_pkg::DIG_CNT_W'(1));

  // format check of the accepted byte
  always_comb begin
    fail = 1'b0;
    unique case (state_q) inside
      sfs_pkg::ST_OPEN1, sfs_pkg::ST_OPEN2: fail = !is_lbr || s_axis_tlast;
      sfs_pkg::ST_NUM1, sfs_pkg::ST_NUM2: begin
        if (is_digit) fail = (cnt_q >= CntW'(MAX_DIGITS)) || s_axis_tlast;
        else if (is_rbr && (cnt_q != '0)) fail = s_axis_tlast;
        else fail = 1'b1;
      end
      sfs_pkg::ST_FIRST: fail = is_lf || is_cr;
      sfs_pkg::ST_TEXT:  fail = is_cr;
      default:           fail = 1'b0;
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sfs_pkg::ST_OPEN1: if (in_acc) state_d = fail ? sfs_pkg::ST_STOP : sfs_pkg::ST_NUM1;
      sfs_pkg::ST_OPEN2: if (in_acc) state_d = fail ? sfs_pkg::ST_STOP : sfs_pkg::ST_NUM2;
      sfs_pkg::ST_NUM1: begin
        if (in_acc) begin
          if (fail) state_d = sfs_pkg::ST_STOP;
          else if (is_rbr) state_d = sfs_pkg::ST_OPEN2;
        end
      end
      sfs_pkg::ST_NUM2: begin
        if (in_acc) begin
          if (fail) state_d = sfs_pkg::ST_STOP;
          else if (is_rbr) state_d = sfs_pkg::ST_FIRST;
        end
      end
      sfs_pkg::ST_FIRST: if (in_acc) state_d = fail ? sfs_pkg::ST_STOP : sfs_pkg::ST_OFF;
      sfs_pkg::ST_TEXT: begin
        if (in_acc) begin
          if (fail) state_d = sfs_pkg::ST_STOP;
          else if (is_lf) state_d = sfs_pkg::ST_OPEN1;
          else if (s_axis_tlast) state_d = sfs_pkg::ST_NL;
        end
      end
      sfs_pkg::ST_OFF:   if (off_done) state_d = sfs_pkg::ST_SUM;
      sfs_pkg::ST_SUM:   state_d = sfs_pkg::ST_CONV;
      sfs_pkg::ST_CONV:  if (bcd_done) state_d = sfs_pkg::ST_OB;
      sfs_pkg::ST_OB:    if (out_free) state_d = neg_q ? sfs_pkg::ST_MINUS : sfs_pkg::ST_SKIP;
      sfs_pkg::ST_MINUS: if (out_free) state_d = sfs_pkg::ST_SKIP;
      sfs_pkg::ST_SKIP:  if (!skip_zero) state_d = sfs_pkg::ST_DIG;
      sfs_pkg::ST_DIG: begin
        if (out_free && (left_q == sfs_pkg::DIG_CNT_W'(1))) state_d = sfs_pkg::ST_CB;
      end
      sfs_pkg::ST_CB:    if (out_free) state_d = sel_q ? sfs_pkg::ST_TXT : sfs_pkg::ST_SUM;
      sfs_pkg::ST_TXT:   if (out_free) state_d = eoi_q ? sfs_pkg::ST_NL : sfs_pkg::ST_TEXT;
      sfs_pkg::ST_NL:    if (out_free) state_d = sfs_pkg::ST_OPEN1;
      sfs_pkg::ST_STOP:  state_d = sfs_pkg::ST_STOP;
      default:           state_d = sfs_pkg::ST_STOP;
    endcase
  end

  // outputs and datapath
  always_comb begin
    out_load   = 1'b0;
    out_byte_n = '0;
    out_err_n  = 1'b0;
    out_last_n = 1'b0;
    off_start  = 1'b0;
    bcd_ctl    = '0;
    bcd_bin    = '0;
    start_d    = start_q;
    end_d      = end_q;
    cnt_d      = cnt_q;
    txt_d      = txt_q;
    eoi_d      = eoi_q;
    sel_d      = sel_q;
    neg_d      = neg_q;
    off_d      = off_q;
    left_d     = left_q;
    if (in_acc && fail) begin
      out_load   = 1'b1;
      out_err_n  = 1'b1;
      out_last_n = 1'b1;
    end else begin
      unique case (state_q)
        sfs_pkg::ST_OPEN1: begin
          if (in_acc) begin
            start_d = '0;
            cnt_d   = '0;
          end
        end
        sfs_pkg::ST_OPEN2: begin
          if (in_acc) begin
            end_d = '0;
            cnt_d = '0;
          end
        end
        sfs_pkg::ST_NUM1: begin
          if (in_acc) begin
            if (is_digit) begin
              start_d = frame_x10[FrameW-1:0];
              cnt_d   = cnt_q + 1'b1;
            end else begin
              cnt_d = '0;
            end
          end
        end
        sfs_pkg::ST_NUM2: begin
          if (in_acc) begin
            if (is_digit) begin
              end_d = frame_x10[FrameW-1:0];
              cnt_d = cnt_q + 1'b1;
            end else begin
              cnt_d = '0;
            end
          end
        end
        sfs_pkg::ST_FIRST: begin
          if (in_acc) begin
            txt_d     = s_axis_tdata;
            eoi_d     = s_axis_tlast;
            sel_d     = 1'b0;
            off_start = 1'b1;
          end
        end
        sfs_pkg::ST_TEXT: begin
          if (in_acc) begin
            out_load   = 1'b1;
            out_byte_n = s_axis_tdata;
            out_last_n = !(s_axis_tlast && !is_lf);
          end
        end
        sfs_pkg::ST_OFF: if (off_done) off_d = off_val;
        sfs_pkg::ST_SUM: begin
          neg_d         = sum_v[SW-1];
          bcd_ctl.start = 1'b1;
          bcd_bin       = sum_mag;
          left_d        = sfs_pkg::DIG_CNT_W'(sfs_pkg::BCD_DIGITS);
        end
        sfs_pkg::ST_OB: begin
          out_load   = out_free;
          out_byte_n = sfs_pkg::CH_LBRACE;
        end
        sfs_pkg::ST_MINUS: begin
          out_load   = out_free;
          out_byte_n = sfs_pkg::CH_MINUS;
        end
        sfs_pkg::ST_SKIP: begin
          // drop leading zeros, keeping the units digit
          if (skip_zero) begin
            bcd_ctl.shift = 1'b1;
            left_d        = left_q - 1'b1;
          end
        end
        sfs_pkg::ST_DIG: begin
          out_byte_n = sfs_pkg::CH_ZERO | {4'b0000, bcd_digit};
          if (out_free) begin
            out_load      = 1'b1;
            bcd_ctl.shift = 1'b1;
            left_d        = left_q - 1'b1;
          end
        end
        sfs_pkg::ST_CB: begin
          out_byte_n = sfs_pkg::CH_RBRACE;
          if (out_free) begin
            out_load = 1'b1;
            sel_d    = 1'b1;
          end
        end
        sfs_pkg::ST_TXT: begin
          out_load   = out_free;
          out_byte_n = txt_q;
          out_last_n = !eoi_q;
        end
        sfs_pkg::ST_NL: begin
          out_load   = out_free;
          out_byte_n = sfs_pkg::CH_LF;
          out_last_n = 1'b1;
        end
        default: ;
      endcase
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q  <= sfs_pkg::FRAME_RATE_RST;
      delay_q <= sfs_pkg::DELAY_MS_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        sfs_pkg::CFG_FRAME_RATE: rate_q  <= cfg_data_i[sfs_pkg::RATE_W-1:0];
        sfs_pkg::CFG_DELAY_MS:   delay_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= sfs_pkg::ST_OPEN1;
      cnt_q     <= '0;
      left_q    <= '0;
      sel_q     <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      left_q  <= left_d;
      sel_q   <= sel_d;
      if (out_load) out_vld_q <= 1'b1;
      else if (m_axis_tready) out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    start_q <= start_d;
    end_q   <= end_d;
    txt_q   <= txt_d;
    eoi_q   <= eoi_d;
    neg_q   <= neg_d;
    off_q   <= off_d;
    if (out_load) begin
      out_byte_q <= out_byte_n;
      out_err_q  <= out_err_n;
      out_last_q <= out_last_n;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_byte_q;
  assign m_axis_tuser  = out_err_q;
  assign m_axis_tlast  = out_last_q;

endmodule
